### rtl/assert_macros.svh
// Assertion macros included by the search module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, muted while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check an implication on every rising clock edge, muted while reset is held.
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error(msg);

`endif

### rtl/hss_pkg.sv
// Shared constants, register indexes and the shift rule of the substring search.
`default_nettype none

package hss_pkg;

	localparam int DEF_PATTERN_MAX = 16;
	localparam int DEF_TEXT_MAX    = 256;

	localparam int PLEN_W     = 5;
	localparam int PAT_BYTES  = 16;
	localparam int PAT_W      = 8 * PAT_BYTES;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

	// Distance from the last occurrence of c among positions 0..m-2 to the
	// pattern end, or m when c does not occur there.
	function automatic logic [PLEN_W-1:0] hss_shift(input logic [7:0] c,
			input logic [PAT_W-1:0] pat, input logic [PLEN_W-1:0] m);
		logic [PLEN_W-1:0] sh;
		sh = m;
		for (int k = 0; k < PAT_BYTES - 1; k++) begin
			if ((PLEN_W'(k + 1) < m) && (pat[8*k +: 8] == c)) begin
				sh = m - PLEN_W'(k + 1);
			end
		end
		return sh;
	endfunction

endpackage

`default_nettype wire

### rtl/hss_if.sv
// Channel interfaces of the substring search: text words, results, register writes.
`default_nettype none

interface hss_text_if ();
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       last_byte;

	modport source (output valid, output text_byte, output last_byte, input ready);
	modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface hss_result_if ();
	logic       valid;
	logic       ready;
	logic       found;
	logic [7:0] match_position;
	logic       overflow;

	modport source (output valid, output found, output match_position, output overflow,
		input ready);
	modport sink (input valid, input found, input match_position, input overflow,
		output ready);
endinterface

interface hss_cfg_if import hss_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/hss_text_mem.sv
// Text buffer: one write port, one read port with registered read data.
`default_nettype none

module hss_text_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### rtl/horspool_substring_search.sv
// Horspool search: text words are buffered one a cycle, then searched on the last word.
// Collecting stores each word; the last word starts the search, and input stalls.
// An alignment is a fit check, a leftward byte compare and, on a mismatch, a shift step;
// a failed fit check ends the search, and the hand-over is held while a result waits.
// Reset clears the fill count, overflow flag, sequencer and result valid, and sets the
// pattern registers to zero and the length to one; the buffer needs no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module horspool_substring_search import hss_pkg::*; #(
	parameter int PATTERN_MAX = DEF_PATTERN_MAX,
	parameter int TEXT_MAX    = DEF_TEXT_MAX
) (
	input  logic         clk,
	input  logic         arst_n,
	hss_text_if.sink     text,
	hss_result_if.source result,
	hss_cfg_if.sink      cfg
);

	localparam int AW = $clog2(TEXT_MAX);
	localparam int CW = $clog2(TEXT_MAX + 1);
	localparam int IW = CW + 1;

	localparam logic [2:0] ST_COLLECT = 3'd0;
	localparam logic [2:0] ST_ALIGN   = 3'd1;
	localparam logic [2:0] ST_CMP     = 3'd2;
	localparam logic [2:0] ST_SHIFT   = 3'd3;
	localparam logic [2:0] ST_DONE    = 3'd4;

	logic [2:0]        state_q;
	logic [PAT_W-1:0]  pattern_q;
	logic [PLEN_W-1:0] plen_q;
	logic [CW-1:0]     count_q;
	logic              dropped_q;
	logic [PLEN_W-1:0] m_q;
	logic [PLEN_W-1:0] j_q;
	logic [IW-1:0]     i_q;
	logic [7:0]        tail_q;
	logic              found_q;
	logic [IW-1:0]     pos_q;

	logic              out_valid_q;
	logic              out_found_q;
	logic [7:0]        out_pos_q;
	logic              out_overflow_q;

	logic              text_acc;
	logic              has_room;
	logic              wr_en;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [7:0]        rd_data;
	logic [PLEN_W-1:0] m_eff;
	logic [3:0]        pidx;
	logic [7:0]        pat_byte;
	logic              fits;
	logic              byte_eq;
	logic              out_free;

	// Effective pattern length: zero acts as one, long values clamp.
	always_comb begin
		if (plen_q == '0) begin
			m_eff = PLEN_W'(1);
		end else if (plen_q > PLEN_W'(PATTERN_MAX)) begin
			m_eff = PLEN_W'(PATTERN_MAX);
		end else begin
			m_eff = plen_q;
		end
	end

	assign text.ready = (state_q == ST_COLLECT);
	assign cfg.ready  = 1'b1;
	assign text_acc   = text.valid && text.ready;
	assign has_room   = (count_q < CW'(TEXT_MAX));
	assign wr_en      = text_acc && has_room;

	assign pidx     = 4'(j_q - PLEN_W'(1));
	assign pat_byte = pattern_q[{pidx, 3'b000} +: 8];
	assign byte_eq  = (rd_data == pat_byte);
	assign fits     = ((i_q + IW'(m_q)) <= IW'(count_q));
	assign out_free = !out_valid_q || result.ready;

	// Read the aligned end byte first, then walk leftwards one byte a cycle.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = AW'(i_q + IW'(m_q) - IW'(1));
		case (state_q)
			ST_ALIGN: begin
				rd_en = fits;
			end
			ST_CMP: begin
				rd_en   = byte_eq && (j_q != PLEN_W'(1));
				rd_addr = AW'(i_q + IW'(j_q) - IW'(2));
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	hss_text_mem #(
		.DEPTH (TEXT_MAX),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (text.text_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			plen_q    <= PLEN_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_PATTERN_LOW:    pattern_q[CFG_DATA_W-1:0]     <= cfg.data;
				REG_PATTERN_HIGH:   pattern_q[PAT_W-1:CFG_DATA_W] <= cfg.data;
				REG_PATTERN_LENGTH: plen_q <= cfg.data[PLEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// The done state refills the result register itself.
			if (result.valid && result.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_COLLECT: begin
					if (text_acc) begin
						if (has_room) begin
							count_q <= count_q + CW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (text.last_byte) begin
							state_q <= ST_ALIGN;
						end
					end
				end
				ST_ALIGN: begin
					if (fits) begin
						state_q <= ST_CMP;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_CMP: begin
					if (!byte_eq) begin
						state_q <= ST_SHIFT;
					end else if (j_q == PLEN_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_SHIFT: begin
					state_q <= ST_ALIGN;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						count_q     <= '0;
						dropped_q   <= 1'b0;
						state_q     <= ST_COLLECT;
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	// Search datapath: alignment, compare index, saved end byte and result word.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_COLLECT: begin
				i_q     <= '0;
				m_q     <= m_eff;
				found_q <= 1'b0;
				pos_q   <= '0;
			end
			ST_ALIGN: begin
				j_q <= m_q;
			end
			ST_CMP: begin
				if (j_q == m_q) begin
					tail_q <= rd_data;
				end
				if (byte_eq) begin
					if (j_q == PLEN_W'(1)) begin
						found_q <= 1'b1;
						pos_q   <= i_q;
					end else begin
						j_q <= j_q - PLEN_W'(1);
					end
				end
			end
			ST_SHIFT: begin
				i_q <= i_q + IW'(hss_shift(tail_q, pattern_q, m_q));
			end
			ST_DONE: begin
				if (out_free) begin
					out_found_q    <= found_q;
					out_pos_q      <= 8'(pos_q);
					out_overflow_q <= dropped_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid          = out_valid_q;
	assign result.found          = out_found_q;
	assign result.match_position = out_pos_q;
	assign result.overflow       = out_overflow_q;

	`ASSERT_CLK(a_count_bound, clk, arst_n, count_q <= CW'(TEXT_MAX), "fill count past capacity")
	`ASSERT_IMPL(a_cmp_index, clk, arst_n, state_q == ST_CMP,
		(j_q != '0) && (j_q <= m_q), "compare index out of pattern")
	`ASSERT_IMPL(a_miss_pos, clk, arst_n, result.valid && !result.found,
		result.match_position == 8'd0, "miss with nonzero position")
	`ASSERT_IMPL(a_clear_after, clk, arst_n, $rose(out_valid_q),
		(count_q == '0) && !dropped_q, "buffer not emptied with result")

endmodule

`default_nettype wire
